[hw/rtl/shmm_pkg.sv]
// ----------------------------------------------------------------------------
// shmm_pkg
// Shared types for the seed hit match merger: table entry, result,
// controller command and status groups, and FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package shmm_pkg;

	localparam int unsigned SEED_LEN_RESET = 20;

	typedef struct packed {
		logic [15:0] hits;
		logic [31:0] lrs;
		logic [31:0] lqs;
		logic [32:0] re;
		logic [31:0] rs;
		logic [32:0] qe;
		logic [31:0] qs;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        ovf;
		logic        flush;
		logic [15:0] hits;
		logic [31:0] refid;
		logic [32:0] re;
		logic [31:0] rs;
		logic [32:0] qe;
		logic [31:0] qs;
	} res_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic merge_wr;
		logic append;
		logic drop;
		logic idx_inc;
		logic scan_init;
		logic emit;
		logic flush_bit;
		logic keep_wr;
		logic filt_end;
		logic flush_end;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic idx_end;
		logic hit;
		logic full;
		logic filt;
		logic pass;
		logic eor;
		logic can_push;
		logic pend_valid;
		logic out_free;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_RD,
		ST_M_EV,
		ST_F_CHK,
		ST_F_RD,
		ST_F_EV,
		ST_E_CHK,
		ST_E_RD,
		ST_E_EV,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/shmm_ram.sv]
// ----------------------------------------------------------------------------
// shmm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module shmm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/shmm_ctrl.sv]
// ----------------------------------------------------------------------------
// shmm_ctrl
// Sequencer: merge scan, filter compaction pass, flush pass, final request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module shmm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire shmm_pkg::stat_t st,
	output shmm_pkg::cmd_t       cmd
);
	shmm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shmm_pkg::ST_IDLE:  if (in_valid) state_d = shmm_pkg::ST_M_RD;
			shmm_pkg::ST_M_RD:  state_d = st.idx_end ? shmm_pkg::ST_F_CHK : shmm_pkg::ST_M_EV;
			shmm_pkg::ST_M_EV:  state_d = st.hit ? shmm_pkg::ST_F_CHK : shmm_pkg::ST_M_RD;
			shmm_pkg::ST_F_CHK: state_d = st.filt ? shmm_pkg::ST_F_RD : shmm_pkg::ST_E_CHK;
			shmm_pkg::ST_F_RD:  state_d = st.idx_end ? shmm_pkg::ST_E_CHK : shmm_pkg::ST_F_EV;
			shmm_pkg::ST_F_EV:  if (!st.pass || st.can_push) state_d = shmm_pkg::ST_F_RD;
			shmm_pkg::ST_E_CHK: state_d = st.eor ? shmm_pkg::ST_E_RD : shmm_pkg::ST_FIN;
			shmm_pkg::ST_E_RD:  state_d = st.idx_end ? shmm_pkg::ST_FIN : shmm_pkg::ST_E_EV;
			shmm_pkg::ST_E_EV:  if (st.can_push) state_d = shmm_pkg::ST_E_RD;
			shmm_pkg::ST_FIN:   if (!st.pend_valid || st.out_free) state_d = shmm_pkg::ST_IDLE;
			default:            state_d = shmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			shmm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			shmm_pkg::ST_M_RD: begin
				if (st.idx_end) begin
					cmd.append = !st.full;
					cmd.drop   = st.full;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			shmm_pkg::ST_M_EV: begin
				cmd.merge_wr = st.hit;
				cmd.idx_inc  = !st.hit;
			end
			shmm_pkg::ST_F_CHK: cmd.scan_init = st.filt;
			shmm_pkg::ST_F_RD: begin
				cmd.filt_end = st.idx_end;
				cmd.rd       = !st.idx_end;
			end
			shmm_pkg::ST_F_EV: begin
				if (st.pass) begin
					cmd.emit    = st.can_push;
					cmd.idx_inc = st.can_push;
				end else begin
					cmd.keep_wr = 1'b1;
					cmd.idx_inc = 1'b1;
				end
			end
			shmm_pkg::ST_E_CHK: cmd.scan_init = st.eor;
			shmm_pkg::ST_E_RD: begin
				cmd.flush_end = st.idx_end;
				cmd.rd        = !st.idx_end;
			end
			shmm_pkg::ST_E_EV: begin
				cmd.emit      = st.can_push;
				cmd.flush_bit = 1'b1;
				cmd.idx_inc   = st.can_push;
			end
			shmm_pkg::ST_FIN: cmd.fin = st.pend_valid && st.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

[hw/rtl/shmm_dp.sv]
// ----------------------------------------------------------------------------
// shmm_dp
// Datapath: item registers, match table, counters, pending and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module shmm_dp #(
	parameter int unsigned MAX_OPEN = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [5:0]      cfg_data,
	input  wire logic [159:0]    in_data,
	input  wire logic            in_last,
	input  wire shmm_pkg::cmd_t  cmd,
	output shmm_pkg::stat_t      st,
	output shmm_pkg::res_t       out_res,
	output logic                 out_last,
	output logic                 out_valid,
	input  wire logic            out_ready
);
	localparam int unsigned IW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
	localparam int unsigned CW = $clog2(MAX_OPEN + 1);

	logic [5:0]    seed_len_q;
	logic [31:0]   qs_q, rs_q, ref_q, lfs_q;
	logic [32:0]   qe_q, re_q;
	logic          eor_q, drop_q;
	logic [CW-1:0] cnt_q, idx_q, w_q;
	logic          pend_valid_q;
	shmm_pkg::res_t pend_q;

	shmm_pkg::entry_t rdata, wdata, upd, fresh;
	logic             we;
	logic [IW-1:0]    waddr;
	shmm_pkg::res_t   new_res;

	shmm_ram #(.WIDTH(shmm_pkg::ENTRY_W), .DEPTH(MAX_OPEN)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (idx_q[IW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		upd      = rdata;
		upd.qe   = (qe_q > rdata.qe) ? qe_q : rdata.qe;
		upd.re   = (re_q > rdata.re) ? re_q : rdata.re;
		upd.lqs  = qs_q;
		upd.lrs  = rs_q;
		upd.hits = (rdata.hits == 16'hFFFF) ? rdata.hits : rdata.hits + 16'd1;
		fresh    = '{hits: 16'd1, lrs: rs_q, lqs: qs_q, re: re_q, rs: rs_q, qe: qe_q, qs: qs_q};
		we       = cmd.merge_wr || cmd.append || cmd.keep_wr;
		waddr    = idx_q[IW-1:0];
		wdata    = upd;
		if (cmd.append) begin
			waddr = cnt_q[IW-1:0];
			wdata = fresh;
		end else if (cmd.keep_wr) begin
			waddr = w_q[IW-1:0];
			wdata = rdata;
		end
	end

	always_comb begin
		new_res = '{ovf: drop_q, flush: cmd.flush_bit, hits: rdata.hits, refid: ref_q,
			re: rdata.re, rs: rdata.rs, qe: rdata.qe, qs: rdata.qs};
	end

	always_comb begin
		st.idx_end    = (idx_q == cnt_q);
		st.hit        = (rdata.lqs < qs_q) && ({1'b0, qs_q} <= rdata.qe)
			&& (rdata.lrs <= rs_q) && ({1'b0, rs_q} <= rdata.re);
		st.full       = (cnt_q == CW'(MAX_OPEN));
		st.filt       = ({1'b0, qs_q} > ({1'b0, lfs_q} + 33'(seed_len_q)));
		st.pass       = (rdata.qe < {1'b0, qs_q});
		st.eor        = eor_q;
		st.out_free   = !out_valid || out_ready;
		st.can_push   = !pend_valid_q || st.out_free;
		st.pend_valid = pend_valid_q;
	end

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qs_q  <= in_data[31:0];
			qe_q  <= {1'b0, in_data[63:32]} + 33'(seed_len_q);
			rs_q  <= in_data[95:64];
			re_q  <= {1'b0, in_data[127:96]} + 33'(seed_len_q);
			ref_q <= in_data[159:128];
			eor_q <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_len_q   <= 6'(shmm_pkg::SEED_LEN_RESET);
			cnt_q        <= '0;
			idx_q        <= '0;
			w_q          <= '0;
			lfs_q        <= '0;
			drop_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) seed_len_q <= cfg_data;
			if (cmd.load || cmd.scan_init) begin
				idx_q <= '0;
				w_q   <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.keep_wr) w_q <= w_q + 1'b1;
			if (cmd.append) cnt_q <= cnt_q + 1'b1;
			if (cmd.drop) drop_q <= 1'b1;
			if (cmd.filt_end) begin
				cnt_q <= w_q;
				lfs_q <= qs_q;
			end
			if (cmd.flush_end) begin
				cnt_q  <= '0;
				lfs_q  <= '0;
				drop_q <= 1'b0;
			end
			if (cmd.emit) pend_valid_q <= 1'b1;
			else if (cmd.fin) pend_valid_q <= 1'b0;
			if ((cmd.emit && pend_valid_q) || cmd.fin) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) pend_q <= new_res;
		if ((cmd.emit && pend_valid_q) || cmd.fin) begin
			out_res  <= pend_q;
			out_last <= cmd.fin;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_OPEN)) else $error("open count beyond table depth");
	a_w_behind: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= idx_q) else $error("compaction write ahead of read");
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !pend_valid_q && out_valid) else $error("final request lost");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && pend_valid_q) |-> (!out_valid || out_ready))
		else $error("output register overwritten");
endmodule
`default_nettype wire

[hw/rtl/seed_hit_match_merger_core.sv]
// ----------------------------------------------------------------------------
// seed_hit_match_merger_core
// Merges seed hits of one reference into approximate matches and emits them.
// ----------------------------------------------------------------------------
// Processing: one hit at a time; the merge scan visits entries until the hit merges or the
// open entries run out, then the filter pass and the flush pass each visit the N open
// entries when they apply, plus the accept, two checks and the final request. Every
// result that waits on the receiver adds its wait. The single read port of the match
// table, each entry read in one state and evaluated in the next, paces every pass.
// Output: a result waits in the pending register until the next result of the hit is
// found or the final request, and then moves to the output register.
// Reset: asynchronous, clears control state; the table itself is never cleared.
`timescale 1ns / 1ps
`default_nettype none
module seed_hit_match_merger_core #(
	parameter int unsigned MAX_OPEN = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// seed_len register
	input  wire logic         cfg_we,
	input  wire logic [5:0]   cfg_data,
	// hit request
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// query_first_pos, query_last_pos, ref_first_pos, ref_last_pos, reference_id
	input  wire logic [159:0] s_tdata,
	input  wire logic         s_tlast,   // end_of_reference
	// match request
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// match_query_start, match_query_end, match_ref_start, match_ref_end,
	// match_reference, match_hits, zero pad to 184 bits
	output logic [183:0]      m_tdata,
	output logic [1:0]        m_tuser,   // from_flush, overflow_seen
	output logic              m_tlast    // last_of_run
);
	shmm_pkg::cmd_t  cmd;
	shmm_pkg::stat_t st;
	shmm_pkg::res_t  res;

	// controller: walks the merge, filter and flush passes
	shmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: table, counters, pending result and output register
	shmm_dp #(.MAX_OPEN(MAX_OPEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.st        (st),
		.out_res   (res),
		.out_last  (m_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	// pack the result fields, lowest first
	assign m_tdata = {6'd0, res.hits, res.refid, res.re, res.rs, res.qe, res.qs};
	assign m_tuser = {res.ovf, res.flush};
endmodule
`default_nettype wire

[tb/sv/seed_hit_match_merger_core_test.sv]
// ----------------------------------------------------------------------------
// seed_hit_match_merger_core_test
// Self-checking bench for the match merger: drives seed hits over the input
// stream, predicts the merged matches in a model of the open table and checks
// every output request field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module seed_hit_match_merger_core_test;

	localparam int unsigned OPEN_DEPTH = 64;
	localparam int unsigned RUN_LIMIT  = 1500000;

	typedef struct {
		logic [31:0] qs;
		logic [31:0] ql;
		logic [31:0] rs;
		logic [31:0] rl;
		logic [31:0] refid;
		logic        eor;
	} hit_t;

	typedef struct packed {
		logic [31:0] qs;
		logic [32:0] qe;
		logic [31:0] rs;
		logic [32:0] re;
		logic [31:0] refid;
		logic [15:0] hits;
		logic        flush;
		logic        ovf;
		logic        last;
	} match_t;

	// directed row: the hit, and an optional hand-written expectation of one match
	typedef struct {
		hit_t   h;
		logic   typed;
		match_t m;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [5:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [183:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	seed_hit_match_merger_core #(.MAX_OPEN(OPEN_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: a copy of the open table and group flags
	logic [5:0]  pr_seed_len;
	logic [31:0] tb_qs [OPEN_DEPTH];
	logic [32:0] tb_qe [OPEN_DEPTH];
	logic [31:0] tb_rs [OPEN_DEPTH];
	logic [32:0] tb_re [OPEN_DEPTH];
	logic [31:0] tb_lqs [OPEN_DEPTH];
	logic [31:0] tb_lrs [OPEN_DEPTH];
	logic [15:0] tb_hits [OPEN_DEPTH];
	int unsigned tb_count;
	logic [32:0] tb_filter_start;
	logic        tb_dropped;

	match_t pending_matches[$];
	int     mismatches = 0;
	int     cycle_count = 0;
	bit     quiet_rx = 1'b0;   // long stretch with no idling
	bit     quiet_tx = 1'b0;
	int     hold_rx = 0;       // long receiver hold-off, in cycles

	function automatic match_t table_match(int unsigned e, logic [31:0] refid, logic fl);
		match_t m;
		m.qs = tb_qs[e]; m.qe = tb_qe[e]; m.rs = tb_rs[e]; m.re = tb_re[e];
		m.refid = refid; m.hits = tb_hits[e]; m.flush = fl; m.ovf = tb_dropped;
		m.last = 1'b0;
		return m;
	endfunction

	// append one expectation behind the others
	task automatic queue_match(input match_t m);
		pending_matches.insert(pending_matches.size(), m);
	endtask

	// merge, filter and flush one hit; queue the matches it releases
	task automatic merge_hit(input hit_t h);
		logic [32:0] qe, re;
		bit merged;
		int unsigned w, n0;
		qe = {1'b0, h.ql} + pr_seed_len;
		re = {1'b0, h.rl} + pr_seed_len;
		merged = 1'b0;
		n0 = pending_matches.size();
		for (int unsigned i = 0; i < tb_count && !merged; i++) begin
			if (tb_lqs[i] < h.qs && {1'b0, h.qs} <= tb_qe[i] &&
			    tb_lrs[i] <= h.rs && {1'b0, h.rs} <= tb_re[i]) begin
				if (qe > tb_qe[i]) tb_qe[i] = qe;
				if (re > tb_re[i]) tb_re[i] = re;
				tb_lqs[i] = h.qs;
				tb_lrs[i] = h.rs;
				if (tb_hits[i] != 16'hFFFF) tb_hits[i]++;
				merged = 1'b1;
			end
		end
		if (!merged) begin
			if (tb_count < OPEN_DEPTH) begin
				tb_qs[tb_count] = h.qs; tb_qe[tb_count] = qe;
				tb_rs[tb_count] = h.rs; tb_re[tb_count] = re;
				tb_lqs[tb_count] = h.qs; tb_lrs[tb_count] = h.rs;
				tb_hits[tb_count] = 16'd1;
				tb_count++;
			end else begin
				tb_dropped = 1'b1;
			end
		end
		if ({1'b0, h.qs} > tb_filter_start + pr_seed_len) begin
			w = 0;
			for (int unsigned i = 0; i < tb_count; i++) begin
				if (tb_qe[i] < {1'b0, h.qs}) begin
					queue_match(table_match(i, h.refid, 1'b0));
				end else begin
					tb_qs[w] = tb_qs[i]; tb_qe[w] = tb_qe[i];
					tb_rs[w] = tb_rs[i]; tb_re[w] = tb_re[i];
					tb_lqs[w] = tb_lqs[i]; tb_lrs[w] = tb_lrs[i];
					tb_hits[w] = tb_hits[i];
					w++;
				end
			end
			tb_count = w;
			tb_filter_start = {1'b0, h.qs};
		end
		if (h.eor) begin
			for (int unsigned i = 0; i < tb_count; i++)
				queue_match(table_match(i, h.refid, 1'b1));
			tb_count = 0;
			tb_filter_start = '0;
			tb_dropped = 1'b0;
		end
		if (pending_matches.size() > n0)
			pending_matches[pending_matches.size() - 1].last = 1'b1;
	endtask

	// offer one hit request and hold it until accepted, then drop valid
	task automatic send_hit(input hit_t h);
		@(posedge clk);
		while (!quiet_tx && $urandom_range(99) < 30) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {h.refid, h.rl, h.rs, h.ql, h.qs};
		s_tlast  <= h.eor;
		merge_hit(h);
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_seed_len(input logic [5:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		pr_seed_len = v;
	endtask

	function automatic hit_t mk(logic [31:0] qs, logic [31:0] ql, logic [31:0] rs,
	                            logic [31:0] rl, logic [31:0] refid, logic eor);
		hit_t h;
		h.qs = qs; h.ql = ql; h.rs = rs; h.rl = rl; h.refid = refid; h.eor = eor;
		return h;
	endfunction

	// receiver: random back-pressure, plus one long hold-off
	always @(posedge clk) begin
		if (hold_rx > 0) begin
			hold_rx <= hold_rx - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_rx || ($urandom_range(99) >= 30);
		end
	end

	// check each accepted match against the oldest expectation
	always @(posedge clk) begin
		match_t got, want;
		cycle_count <= cycle_count + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got.qs = m_tdata[31:0];     got.qe = m_tdata[64:32];
			got.rs = m_tdata[96:65];    got.re = m_tdata[129:97];
			got.refid = m_tdata[161:130]; got.hits = m_tdata[177:162];
			got.flush = m_tuser[0];     got.ovf = m_tuser[1];
			got.last = m_tlast;
			if (pending_matches.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected match %p", got);
			end else begin
				want = pending_matches.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= RUN_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	row_t rows[$];

	task automatic add_row(input hit_t h, input logic typed, input match_t m);
		row_t r;
		r.h = h; r.typed = typed; r.m = m;
		rows.insert(rows.size(), r);
	endtask

	// random hit inside a group walking the query forward
	task automatic random_group(input logic [31:0] refid, input int len, input logic full_range);
		logic [31:0] q, r, step;
		q = full_range ? $urandom : $urandom_range(1000);
		r = full_range ? $urandom : $urandom_range(1000);
		for (int k = 0; k < len; k++) begin
			hit_t h;
			step = $urandom_range(3) == 0 ? $urandom_range(80) : $urandom_range(12);
			q = q + step;
			r = r + step + $urandom_range(2);
			h = mk(q, q + $urandom_range(40), r, r + $urandom_range(40), refid, k == len - 1);
			case ($urandom_range(9))
				0: h.qs = $urandom;
				1: h.rs = $urandom;
				2: begin h.ql = $urandom; h.rl = $urandom; end
				3: h.eor = 1'($urandom_range(1));
				default: ;
			endcase
			send_hit(h);
		end
	endtask

	initial begin
		match_t z, m;
		z = '{default: '0};
		pr_seed_len = 6'(shmm_pkg::SEED_LEN_RESET);
		tb_count = 0; tb_filter_start = '0; tb_dropped = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a lone end-of-reference hit after reset flushes itself at once
		m = '{qs: 32'd100, qe: 33'd125, rs: 32'd7, re: 33'd37, refid: 32'd3,
		      hits: 16'd1, flush: 1'b1, ovf: 1'b0, last: 1'b1};
		add_row(mk(100, 105, 7, 17, 3, 1'b1), 1'b1, m);
		// extremes: largest positions, ends carried into bit 32
		m = '{qs: '1, qe: 33'h1_0000_0013, rs: '1, re: 33'h1_0000_0013,
		      refid: '1, hits: 16'd1, flush: 1'b1, ovf: 1'b0, last: 1'b1};
		add_row(mk('1, '1, '1, '1, '1, 1'b1), 1'b1, m);
		// zero hit, a merge, an overlap miss, a pass and a reference change
		add_row(mk(0, 0, 0, 0, 0, 1'b0), 1'b0, z);
		add_row(mk(5, 10, 5, 10, 0, 1'b0), 1'b0, z);
		add_row(mk(5, 12, 5, 12, 0, 1'b0), 1'b0, z);
		add_row(mk(300, 310, 900, 910, 1, 1'b0), 1'b0, z);
		add_row(mk(305, 315, 100, 110, 2, 1'b0), 1'b0, z);
		// last strobe before first strobe
		add_row(mk(400, 10, 950, 3, 2, 1'b0), 1'b0, z);
		add_row(mk(1000, 1005, 2000, 2005, 2, 1'b1), 1'b0, z);
		foreach (rows[i]) begin
			send_hit(rows[i].h);
			if (rows[i].typed) begin
				// the hand-written expectation stands in for the predicted one
				pending_matches.delete();
				queue_match(rows[i].m);
			end
			drain();
		end

		// full table: 70 disjoint hits at one query spot, then flush
		write_seed_len(6'd8);
		for (int k = 0; k < 70; k++)
			send_hit(mk(32'd10 + (k == 0 ? 0 : 1), 32'd10, 32'd100 * k, 32'd100 * k,
			             9, 1'b0));
		send_hit(mk(12, 12, 32'hFFFF_0000, 32'hFFFF_0000, 9, 1'b1));

		// pressure: hold the receiver off while hits keep coming
		write_seed_len(6'd32);
		hold_rx = 3000;
		for (int k = 0; k < 20; k++)
			send_hit(mk(32'd50 * k, 32'd50 * k + 3, 32'd50 * k, 32'd50 * k, 4, k == 19));

		// random part over several settings, the extremes among them
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_seed_len(6'd0);
				1: write_seed_len(6'd63);
				2: write_seed_len(6'd8);
				3: write_seed_len(6'd32);
				default: write_seed_len(6'($urandom_range(8, 32)));
			endcase
			quiet_rx = (phase == 3);
			quiet_tx = (phase == 3);
			for (int g = 0; g < 2; g++)
				random_group($urandom, $urandom_range(3, 10), phase == 1);
		end
		quiet_rx = 1'b0;
		quiet_tx = 1'b0;

		drain();
		if (mismatches == 0 && pending_matches.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[seed_hit_match_merger_core.f]
hw/rtl/shmm_pkg.sv
hw/rtl/shmm_ram.sv
hw/rtl/shmm_ctrl.sv
hw/rtl/shmm_dp.sv
hw/rtl/seed_hit_match_merger_core.sv
tb/sv/seed_hit_match_merger_core_test.sv
